// ===== src/vts_pkg.sv =====
// shared constants for the vector trajectory sampler
// no dependencies; imported by vts_alpha_div and vector_trajectory_sampler
package vts_pkg;

    localparam int MAX_KNOTS_DEF  = 64;
    localparam int VECTOR_LEN_DEF = 6;
    localparam int ELEMS_MAX      = 6;
    localparam int ELEM_IW        = 3;
    localparam int WORD_W         = 32;

    // alpha is q0.16: one quotient bit per divider step
    localparam int DIV_STEPS      = 16;
    localparam int DIV_CW         = 5;

    localparam logic       MODE_LOAD      = 1'b0;
    localparam logic       MODE_QUERY     = 1'b1;
    localparam logic [7:0] CFG_KNOT_COUNT = 8'd0;
    localparam logic [7:0] CFG_INTERP     = 8'd1;

    localparam logic [6:0]  KNOT_COUNT_RST = 7'd1;
    localparam logic [51:0] ROUND_HALF     = 52'd32768;

endpackage

// ===== src/vts_alpha_div.sv =====
// restoring divider for the blend ratio: floor(elapsed * 2^16 / duration)
// depends on vts_pkg; expects elapsed < duration
module vts_alpha_div
    import vts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [32:0] elapsed,
    input  logic [32:0] duration,
    output logic        done,
    output logic [15:0] quotient
);

    logic [33:0]       rem_reg, rem_next;
    logic [33:0]       dur_reg;
    logic [15:0]       q_reg, q_next;
    logic [DIV_CW-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [33:0]       shifted;

    always_comb
    begin
        shifted = {rem_reg[32:0], 1'b0};
        if (shifted >= dur_reg)
        begin
            rem_next = shifted - dur_reg;
            q_next   = {q_reg[14:0], 1'b1};
        end
        else
        begin
            rem_next = shifted;
            q_next   = {q_reg[14:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            // pulse after the last quotient bit
            done_reg <= !start && busy_reg && (cnt_reg == DIV_CW'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CW'(DIV_STEPS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CW'(1))
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= {1'b0, elapsed};
            dur_reg <= {1'b0, duration};
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            q_reg   <= q_next;
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// ===== src/vector_trajectory_sampler.sv =====
// top level of the vector trajectory sampler: knot memories and query sequencer
// depends on vts_pkg and vts_alpha_div
//
// usage
//   s_* carries load and query items, m_* carries one result item per query,
//   cfg_* writes knot_count (index 0) and interpolate_enable (index 1)
//   a load item writes one knot time and one channel row
//   a query reads knot 0, then the last valid knot, then scans knots from 1
//   upward one read per cycle until a later time is found (unsorted tables
//   follow index order), then reads the lower and upper vector rows
//   a blended query adds a divider wait and a multiply and an accumulate step
//   per element; a query time at or below the time of knot 0, or at or above
//   that of the last valid knot, skips the scan; the sequential scan over the
//   time memory port and the serial divider set how long a query takes
//   the block takes one item at a time; s_tready is high only while idle
//   a finished result sits in the output register, so a new item can be
//   taken while the receiver stalls; a second result waits for that slot
//   reset sets control state and config (knot_count 1, interpolation off); data
//   registers and memories stay unwritten and need no clearing pass
module vector_trajectory_sampler
    import vts_pkg::*;
#(
    parameter int MAX_KNOTS  = MAX_KNOTS_DEF,
    parameter int VECTOR_LEN = VECTOR_LEN_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // knot_slot[5:0], time_point[37:6], elem_a..elem_f[229:38], zero pad
    input  logic [231:0] s_tdata,
    // mode[0], channel[1]
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_a..out_f[191:0], lower_knot[197:192], blend_ratio[214:198], zero pad
    output logic [215:0] m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [7:0]   cfg_index,
    input  logic [6:0]   cfg_data
);

    localparam int AW = (MAX_KNOTS > 1) ? $clog2(MAX_KNOTS) : 1;
    localparam int RW = VECTOR_LEN * WORD_W;

    typedef enum logic [3:0] {
        S_IDLE, S_T0, S_TL, S_SCAN, S_VLO, S_VUP, S_DIV, S_MUL, S_ACC, S_DONE
    } state_t;

    // memories: knot times, and vector rows addressed by {channel, knot}
    logic signed [31:0] times_mem [2**AW];
    logic [RW-1:0]      vec_mem   [2**(AW+1)];

    state_t             state_reg;
    logic [6:0]         knot_count_reg;
    logic               interp_reg;
    logic signed [31:0] t_reg;
    logic               chan_reg;
    logic [AW-1:0]      k_reg, lo_reg, up_reg;
    logic signed [31:0] tprev_reg, tlo_reg, tup_reg;
    logic               blend_reg;
    logic [RW-1:0]      v0_reg;
    logic [16:0]        alpha_reg;
    logic [ELEM_IW-1:0] e_reg;
    logic signed [50:0] prod_reg;
    logic [31:0]        res_reg [ELEMS_MAX];
    logic               out_valid_reg;
    logic [215:0]       out_data_reg;

    logic signed [31:0] t_q;
    logic [RW-1:0]      vec_q;
    logic [AW-1:0]      t_raddr;
    logic [AW:0]        v_raddr;
    logic [AW-1:0]      nm1;
    logic               in_fire, load_ok, div_start, div_done;
    logic [15:0]        div_q;
    logic [31:0]        slot_ext;
    logic [32:0]        el33, dur33;
    logic signed [32:0] diff_e;
    logic signed [51:0] acc;
    logic [31:0]        v0_e, v1_e;
    logic [31:0]        elem_in [ELEMS_MAX];
    logic [RW-1:0]      row_in;

    assign in_fire   = s_tvalid && s_tready;
    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    // clamp the valid knot count to 1..MAX_KNOTS
    always_comb
    begin
        if (knot_count_reg == 7'd0)
            nm1 = '0;
        else if (32'(knot_count_reg) > 32'(MAX_KNOTS))
            nm1 = AW'(MAX_KNOTS - 1);
        else
            nm1 = AW'(32'(knot_count_reg) - 32'd1);
    end

    assign slot_ext = 32'(s_tdata[5:0]);
    assign load_ok  = in_fire && (s_tuser[0] == MODE_LOAD) && (slot_ext < 32'(MAX_KNOTS));

    always_comb
    begin
        for (int i = 0; i < ELEMS_MAX; i++)
            elem_in[i] = s_tdata[38 + i*32 +: 32];
        for (int i = 0; i < VECTOR_LEN; i++)
            row_in[i*32 +: 32] = elem_in[i];
    end

    // read addresses follow the sequencer; lower row only in S_VLO
    always_comb
    begin
        case (state_reg)
            S_IDLE:  t_raddr = '0;
            S_T0:    t_raddr = nm1;
            S_TL:    t_raddr = AW'(1);
            S_SCAN:  t_raddr = k_reg + AW'(1);
            default: t_raddr = k_reg;
        endcase
        v_raddr = (state_reg == S_VLO) ? {chan_reg, lo_reg} : {chan_reg, up_reg};
    end

    always_ff @(posedge clk)
    begin
        if (load_ok)
        begin
            times_mem[slot_ext[AW-1:0]]                 <= $signed(s_tdata[37:6]);
            vec_mem[{s_tuser[1], slot_ext[AW-1:0]}]     <= row_in;
        end
        t_q   <= times_mem[t_raddr];
        vec_q <= vec_mem[v_raddr];
    end

    assign el33      = 33'($signed({t_reg[31], t_reg}) - $signed({tlo_reg[31], tlo_reg}));
    assign dur33     = 33'($signed({tup_reg[31], tup_reg}) - $signed({tlo_reg[31], tlo_reg}));
    assign div_start = (state_reg == S_VUP) && blend_reg;

    vts_alpha_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .elapsed  (el33),
        .duration (dur33),
        .done     (div_done),
        .quotient (div_q)
    );

    // each element takes a multiply and an accumulate step: v0*2^16 + (v1-v0)*alpha, rounded half up
    assign v0_e   = v0_reg[32'(e_reg)*32 +: 32];
    assign v1_e   = vec_q[32'(e_reg)*32 +: 32];
    assign diff_e = $signed({v1_e[31], v1_e}) - $signed({v0_e[31], v0_e});
    assign acc    = $signed({{4{v0_e[31]}}, v0_e, 16'd0}) + 52'(prod_reg)
                    + $signed(ROUND_HALF);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            knot_count_reg <= KNOT_COUNT_RST;
            interp_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
            blend_reg      <= 1'b0;
            k_reg          <= '0;
            lo_reg         <= '0;
            up_reg         <= '0;
            e_reg          <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_KNOT_COUNT: knot_count_reg <= cfg_data;
                    CFG_INTERP:     interp_reg     <= cfg_data[0];
                    default:        ;
                endcase
            end

            // output slot: filled from S_DONE, emptied when the receiver takes it
            if ((state_reg == S_DONE) && (!out_valid_reg || m_tready))
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && m_tready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (in_fire && (s_tuser[0] == MODE_QUERY))
                    begin
                        t_reg     <= $signed(s_tdata[37:6]);
                        chan_reg  <= s_tuser[1];
                        state_reg <= S_T0;
                    end
                end
                S_T0:
                begin
                    tprev_reg <= t_q;
                    blend_reg <= 1'b0;
                    if (t_reg <= t_q)
                    begin
                        lo_reg    <= '0;
                        up_reg    <= '0;
                        state_reg <= S_VLO;
                    end
                    else
                        state_reg <= S_TL;
                end
                S_TL:
                begin
                    if (t_reg >= t_q)
                    begin
                        lo_reg    <= nm1;
                        up_reg    <= nm1;
                        state_reg <= S_VLO;
                    end
                    else
                    begin
                        k_reg     <= AW'(1);
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if ((t_q > t_reg) || (k_reg == nm1))
                    begin
                        up_reg    <= k_reg;
                        lo_reg    <= k_reg - AW'(1);
                        tup_reg   <= t_q;
                        tlo_reg   <= tprev_reg;
                        blend_reg <= interp_reg;
                        state_reg <= S_VLO;
                    end
                    else
                    begin
                        tprev_reg <= t_q;
                        k_reg     <= k_reg + AW'(1);
                    end
                end
                S_VLO:
                    state_reg <= S_VUP;
                S_VUP:
                begin
                    v0_reg <= vec_q;
                    if (blend_reg)
                        state_reg <= S_DIV;
                    else
                    begin
                        for (int i = 0; i < ELEMS_MAX; i++)
                            res_reg[i] <= (i < VECTOR_LEN) ? vec_q[i*32 +: 32] : '0;
                        alpha_reg <= '0;
                        state_reg <= S_DONE;
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        alpha_reg <= {1'b0, div_q};
                        e_reg     <= '0;
                        for (int i = 0; i < ELEMS_MAX; i++)
                            res_reg[i] <= '0;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    prod_reg  <= 51'(diff_e * $signed({1'b0, alpha_reg}));
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    res_reg[e_reg] <= acc[47:16];
                    if (e_reg == ELEM_IW'(VECTOR_LEN - 1))
                        state_reg <= S_DONE;
                    else
                    begin
                        e_reg     <= e_reg + 1'b1;
                        state_reg <= S_MUL;
                    end
                end
                S_DONE:
                begin
                    if (!out_valid_reg || m_tready)
                        state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // result register, loaded when the output slot frees up
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_DONE) && (!out_valid_reg || m_tready))
        begin
            for (int i = 0; i < ELEMS_MAX; i++)
                out_data_reg[i*32 +: 32] <= res_reg[i];
            out_data_reg[197:192] <= 6'(32'(lo_reg));
            out_data_reg[214:198] <= alpha_reg;
            out_data_reg[215]     <= 1'b0;
        end
    end

    // no item taken while a query is in flight
    a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !s_tready)
        else $error("input taken while busy");

    // blend always spans two adjacent knots
    a_blend_adjacent: assert property (@(posedge clk) disable iff (!rst_n)
        (blend_reg && (state_reg == S_MUL)) |-> (up_reg == lo_reg + AW'(1)))
        else $error("blend knots not adjacent");

    // divider finishes only while the sequencer waits for it
    a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("divider result unexpected");

    // a new result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |=> (out_valid_reg && $stable(out_data_reg)))
        else $error("waiting result lost");

endmodule
